// ===== sv/cmht_pkg.sv =====
// Types and codes shared by the CAN message health table.
// Holds the input item and result structs, the stored record layout and the status codes.
// Depends on nothing.
package cmht_pkg;

    localparam int unsigned ID_W       = 29;
    localparam int unsigned META_W     = 10;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned SLOT_OUT_W = 5;

    localparam logic [1:0] VALIDITY_VALID     = 2'd0;
    localparam logic [1:0] VALIDITY_MALFORMED = 2'd1;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_IGNORED    = 3'd1,
        ST_CAPACITY   = 3'd2,
        ST_OLDER      = 3'd3,
        ST_CONFLICT   = 3'd4,
        ST_IDEMPOTENT = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        H_UNKNOWN = 2'd0,
        H_HEALTHY = 2'd1,
        H_FAULTED = 2'd2
    } health_t;

    typedef struct packed {
        logic [1:0]        validity;
        logic [ID_W-1:0]   frame_identifier;
        logic              extended_format;
        logic              remote_flag;
        logic [3:0]        bus_number;
        logic [3:0]        length_code;
        logic [WORD_W-1:0] payload;
        logic [WORD_W-1:0] frame_time_us;
    } frame_t;

    typedef struct packed {
        status_t               status;
        health_t               record_health;
        logic [SLOT_OUT_W-1:0] slot_index;
    } result_t;

    // One stored record, apart from the identifier, which has a memory of its own.
    typedef struct packed {
        logic [META_W-1:0] metadata;
        logic [WORD_W-1:0] payload;
        logic [WORD_W-1:0] watermark_us;
        health_t           health;
        logic              accepted_valid;
        logic [WORD_W-1:0] good_time_us;
        logic              fault_valid;
        logic [WORD_W-1:0] fault_us;
    } record_t;

endpackage

// ===== sv/can_message_health_table_unit.sv =====
// CAN message health table, top level: scan engine, record update and both memories.
// Depends on cmht_pkg.
//
// Usage: drive an observed frame on frame and raise start; the item is taken at a
// clock edge where start is high and busy is low. Exactly one result per item comes
// back on result, marked by done for a single cycle; the receiver cannot stall it.
// An ignored frame (validity code 2 or 3) is answered in the next cycle and busy stays
// low. Any other frame scans the identifier memory one slot per cycle, one read in
// flight, until the identifier is found or every slot has been seen, while noting the
// lowest free slot. A full table is answered from the scan; otherwise the record is
// read from the record memory in S_READ and written back in S_UPDATE when the frame
// is stored. The identifier scan runs over the single read port of the identifier
// memory. For a frame that is not ignored, busy is high from the accept edge until
// done is raised, so one item is in work at a time and the memories never see
// overlapping accesses to one entry.
// Reset clears the slot valid flags at once; the memories need no clearing pass.
module can_message_health_table_unit #(
    parameter int unsigned NUM_SLOTS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmht_pkg::frame_t frame,
    output logic             done,
    output cmht_pkg::result_t result
);
    import cmht_pkg::*;

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_UPDATE
    } state_t;

    state_t                 state_reg;
    frame_t                 item_reg;
    logic [NUM_SLOTS-1:0]   used_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic                   cmp_valid_reg;
    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic                   hit_reg;
    logic                   done_reg;
    result_t                result_reg;

    logic [ID_W-1:0]        id_mem [NUM_SLOTS];
    record_t                rec_mem [NUM_SLOTS];
    logic [ID_W-1:0]        id_rdata;
    record_t                rec_rdata;

    logic                   accept;
    logic                   ignored;
    logic                   id_match;
    logic                   cur_free;
    logic                   scan_last;
    logic [META_W-1:0]      item_meta;
    logic                   fresh;
    logic                   older;
    logic                   rec_we;
    record_t                rec_wdata;
    status_t                upd_status;
    health_t                upd_health;
    logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;

    assign accept    = start && (state_reg == S_IDLE);
    assign ignored   = frame.validity[1];
    assign id_match  = used_reg[cmp_idx_reg] && (id_rdata == item_reg.frame_identifier);
    assign cur_free  = !used_reg[cmp_idx_reg];
    assign scan_last = (cmp_idx_reg == LAST_IDX);
    assign item_meta = {item_reg.length_code, item_reg.bus_number,
                        item_reg.remote_flag, item_reg.extended_format};
    assign slot_ext  = (IDX_W + SLOT_OUT_W)'(slot_reg);

    // Decision on the record that the scan selected; a slot not yet used is always fresh.
    assign fresh = !hit_reg || (item_reg.frame_time_us > rec_rdata.watermark_us);
    assign older = item_reg.frame_time_us < rec_rdata.watermark_us;

    always_comb
    begin
        rec_wdata  = rec_rdata;
        // A slot not used yet starts from cleared flags and an unknown health.
        if (!hit_reg)
        begin
            rec_wdata.health         = H_UNKNOWN;
            rec_wdata.accepted_valid = 1'b0;
            rec_wdata.fault_valid    = 1'b0;
        end
        rec_we     = 1'b0;
        upd_status = ST_OLDER;
        upd_health = rec_rdata.health;
        if (item_reg.validity == VALIDITY_MALFORMED)
        begin
            if (fresh || (!older && rec_rdata.health != H_FAULTED))
            begin
                if (fresh)
                begin
                    rec_wdata.metadata     = item_meta;
                    rec_wdata.payload      = item_reg.payload;
                    rec_wdata.watermark_us = item_reg.frame_time_us;
                end
                rec_wdata.health      = H_FAULTED;
                rec_wdata.fault_valid = 1'b1;
                rec_wdata.fault_us    = item_reg.frame_time_us;
                rec_we     = 1'b1;
                upd_status = ST_ACCEPTED;
                upd_health = H_FAULTED;
            end
            else if (!older)
            begin
                upd_status = ST_IDEMPOTENT;
                upd_health = H_FAULTED;
            end
        end
        else
        begin
            if (fresh)
            begin
                rec_wdata.metadata       = item_meta;
                rec_wdata.payload        = item_reg.payload;
                rec_wdata.watermark_us   = item_reg.frame_time_us;
                rec_wdata.health         = H_HEALTHY;
                rec_wdata.accepted_valid = 1'b1;
                rec_wdata.good_time_us   = item_reg.frame_time_us;
                rec_wdata.fault_valid    = 1'b0;
                rec_we     = 1'b1;
                upd_status = ST_ACCEPTED;
                upd_health = H_HEALTHY;
            end
            else if (!older)
            begin
                if (rec_rdata.health == H_FAULTED)
                begin
                    upd_status = ST_CONFLICT;
                end
                else if (rec_rdata.metadata == item_meta &&
                         rec_rdata.payload == item_reg.payload)
                begin
                    upd_status = ST_IDEMPOTENT;
                end
                else
                begin
                    upd_status = ST_CONFLICT;
                end
            end
        end
    end

    // Identifier memory: one read a cycle during the scan, written when a fresh frame stores a record.
    always_ff @(posedge clk)
    begin
        id_rdata <= id_mem[rd_idx_reg];
        if (state_reg == S_UPDATE && rec_we && fresh)
        begin
            id_mem[slot_reg] <= item_reg.frame_identifier;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_rdata <= rec_mem[slot_reg];
        if (state_reg == S_UPDATE && rec_we)
        begin
            rec_mem[slot_reg] <= rec_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            rd_idx_reg     <= '0;
            cmp_idx_reg    <= '0;
            cmp_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            slot_reg       <= '0;
            hit_reg        <= 1'b0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (ignored)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{ST_IGNORED, H_UNKNOWN, '0};
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                        rd_idx_reg     <= '0;
                        cmp_valid_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    cmp_valid_reg <= 1'b1;
                    cmp_idx_reg   <= rd_idx_reg;
                    if (rd_idx_reg != LAST_IDX)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (cmp_valid_reg)
                    begin
                        priority if (id_match)
                        begin
                            slot_reg  <= cmp_idx_reg;
                            hit_reg   <= 1'b1;
                            state_reg <= S_READ;
                        end
                        else if (scan_last)
                        begin
                            hit_reg <= 1'b0;
                            if (free_found_reg)
                            begin
                                slot_reg  <= free_idx_reg;
                                state_reg <= S_READ;
                            end
                            else if (cur_free)
                            begin
                                slot_reg  <= cmp_idx_reg;
                                state_reg <= S_READ;
                            end
                            else
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{ST_CAPACITY, H_UNKNOWN, '0};
                                state_reg  <= S_IDLE;
                            end
                        end
                        else if (!free_found_reg && cur_free)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= cmp_idx_reg;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (rec_we)
                    begin
                        used_reg[slot_reg] <= 1'b1;
                    end
                    done_reg   <= 1'b1;
                    result_reg <= '{upd_status, upd_health, slot_ext[SLOT_OUT_W-1:0]};
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result is only raised once the item is finished, so busy is already low.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result raised while an item is still in work");

    a_no_slot_without_record: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_IGNORED || result.status == ST_CAPACITY)
        |-> result.slot_index == '0 && result.record_health == H_UNKNOWN)
        else $error("ignored or capacity result carries a slot or health");

    a_accepted_health: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_ACCEPTED
        |-> result.record_health == H_HEALTHY || result.record_health == H_FAULTED)
        else $error("accepted frame left the record without a known health");

    a_update_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPDATE |-> $past(state_reg) == S_READ)
        else $error("record updated without its memory read");

endmodule
